FILE: sv/ptrt_pkg.sv
// Types and constants shared by the pending transaction retry table.
// No dependencies.
`timescale 1ns / 1ps
package ptrt_pkg;

  typedef enum logic [2:0] {
    CMD_ADD_CLIENT = 3'd0,
    CMD_ADD_SERVER = 3'd1,
    CMD_ADD_ROOM   = 3'd2,
    CMD_RECEIVE    = 3'd3,
    CMD_SCAN       = 3'd4,
    CMD_RELEASE    = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    KIND_ADDED     = 4'd0,
    KIND_FULL      = 4'd1,
    KIND_FOUND     = 4'd2,
    KIND_NOT_FOUND = 4'd3,
    KIND_RESEND    = 4'd4,
    KIND_LOST      = 4'd5,
    KIND_LOST_IMP  = 4'd6,
    KIND_PROCESS   = 4'd7,
    KIND_DONE      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_ADD,
    DP_READ,
    DP_EVAL,
    DP_FIN
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_EVAL,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] age;
    logic [1:0] rcv;
    logic [2:0] retries;
    logic       before_login;
    logic       important;
    logic       payload;
    logic       server;
  } status_t;

  typedef struct packed {
    logic [15:0] code;
    logic [15:0] seq;
    logic [7:0]  room_op;
    logic [31:0] room_number;
    status_t     status;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  typedef struct packed {
    cmd_e in_cmd;
    logic rd_done;
    logic can_emit;
    logic ev_end;
  } dp_stat_t;

  localparam logic [2:0] ADDR_RETRY_BUDGET = 3'd0;
  localparam logic [2:0] ADDR_ROOM_CODE    = 3'd4;
  localparam logic [2:0] RETRY_RESET       = 3'd3;

endpackage

FILE: sv/ptrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ptrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ptrt_ctrl.sv
// Sequencing state machine of the retry table.
// Depends on ptrt_pkg.
`timescale 1ns / 1ps
module ptrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptrt_pkg::dp_stat_t stat_i,
  output ptrt_pkg::dp_op_e   op_o
);
  import ptrt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = DP_NOP;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o = DP_LATCH;
          unique case (stat_i.in_cmd)
            CMD_ADD_CLIENT, CMD_ADD_SERVER, CMD_ADD_ROOM: state_d = ST_ADD;
            CMD_RECEIVE, CMD_SCAN, CMD_RELEASE:          state_d = ST_READ;
            default:                                     state_d = ST_FIN;
          endcase
        end
      end
      ST_ADD: begin
        if (stat_i.can_emit) begin
          op_o    = DP_ADD;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (stat_i.rd_done) begin
          state_d = ST_FIN;
        end else begin
          op_o    = DP_READ;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.can_emit) begin
          op_o    = DP_EVAL;
          state_d = stat_i.ev_end ? ST_IDLE : ST_READ;
        end
      end
      ST_FIN: begin
        if (stat_i.can_emit) begin
          op_o    = DP_FIN;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != ST_IDLE)
    else $error("accepted transaction left controller idle");
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == DP_READ) |=> state_q == ST_EVAL)
    else $error("read not followed by evaluation");
  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == DP_EVAL || op_o == DP_ADD || op_o == DP_FIN) |-> stat_i.can_emit)
    else $error("result issued while output register busy");
`endif

endmodule

FILE: sv/ptrt_dp.sv
// Datapath of the retry table: item register, entry RAM, scan indexes, output register.
// Depends on ptrt_pkg and ptrt_ram.
`timescale 1ns / 1ps
module ptrt_dp #(
  parameter int unsigned TableDepth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptrt_pkg::dp_op_e   op_i,
  output ptrt_pkg::dp_stat_t stat_o,
  input  logic [2:0]         retry_budget_i,
  input  logic [15:0]        room_code_i,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        msg_code_i,
  input  logic [15:0]        msg_seq_i,
  input  logic               important_i,
  input  logic               logged_in_i,
  input  logic               has_payload_i,
  input  logic [7:0]         room_op_i,
  input  logic [31:0]        room_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         kind_o,
  output logic [15:0]        entry_code_o,
  output logic [15:0]        entry_seq_o,
  output logic [7:0]         entry_room_op_o,
  output logic [31:0]        entry_room_number_o,
  output logic               entry_is_server_o,
  output logic               repeat_reply_o,
  output logic               last_o
);
  import ptrt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TableDepth);

  // latched transaction
  cmd_e        cmd_q;
  logic [15:0] code_q, seq_q;
  logic        imp_q, login_q, pay_q;
  logic [7:0]  rop_q;
  logic [31:0] rnum_q;

  logic [CntW-1:0] count_q, count_d, rd_q, rd_d, wr_q, wr_d;
  logic            copy_q, copy_d;

  logic            ovalid_q, ovalid_d;
  kind_e           okind_q, okind_d;
  entry_t          oent_q, oent_d;
  logic            orep_q, orep_d, olast_q, olast_d;

  logic            we, re;
  logic [IdxW-1:0] waddr;
  entry_t          wdata, rdata, add_e;
  logic            can_emit, ev_end, emit;

  ptrt_ram #(.Width(EntryWidth), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(rd_q[IdxW-1:0]),
    .rdata_o(rdata)
  );

  assign can_emit = !ovalid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (op_i == DP_LATCH) begin
      cmd_q   <= cmd_e'(cmd_i);
      code_q  <= msg_code_i;
      seq_q   <= msg_seq_i;
      imp_q   <= important_i;
      login_q <= logged_in_i;
      pay_q   <= has_payload_i;
      rop_q   <= room_op_i;
      rnum_q  <= room_number_i;
    end
    if (emit) begin
      okind_q <= okind_d;
      oent_q  <= oent_d;
      orep_q  <= orep_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      copy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      copy_q   <= copy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // entry built by an add
  always_comb begin
    add_e                     = '0;
    add_e.code                = code_q;
    add_e.seq                 = seq_q;
    add_e.status.payload      = pay_q;
    unique case (cmd_q)
      CMD_ADD_CLIENT: begin
        add_e.status.important = imp_q;
        add_e.status.retries   = retry_budget_i;
      end
      CMD_ADD_SERVER: begin
        add_e.status.server       = 1'b1;
        add_e.status.before_login = !login_q;
        add_e.status.rcv          = 2'd1;
      end
      default: begin
        add_e.code             = room_code_i;
        add_e.room_op          = rop_q;
        add_e.room_number      = rnum_q;
        add_e.status.retries   = retry_budget_i;
      end
    endcase
  end

  always_comb begin
    status_t     ns;
    logic [1:0]  age_n;
    logic        keep;

    count_d = count_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    copy_d  = copy_q;
    we      = 1'b0;
    waddr   = wr_q[IdxW-1:0];
    wdata   = rdata;
    re      = 1'b0;
    emit    = 1'b0;
    ev_end  = 1'b0;
    okind_d = KIND_DONE;
    oent_d  = '0;
    orep_d  = 1'b0;
    olast_d = 1'b1;
    ns      = rdata.status;
    age_n   = (rdata.status.age < 2'd2) ? rdata.status.age + 2'd1 : 2'd2;
    keep    = 1'b1;

    unique case (op_i)
      DP_LATCH: begin
        rd_d   = '0;
        wr_d   = '0;
        copy_d = 1'b0;
      end
      DP_ADD: begin
        emit   = 1'b1;
        oent_d = add_e;
        if (count_q >= DepthC) begin
          okind_d = KIND_FULL;
        end else begin
          okind_d = KIND_ADDED;
          we      = 1'b1;
          waddr   = count_q[IdxW-1:0];
          wdata   = add_e;
          count_d = count_q + 1'b1;
        end
      end
      DP_READ: re = 1'b1;
      DP_EVAL: begin
        rd_d = rd_q + 1'b1;
        unique case (cmd_q)
          CMD_RECEIVE: begin
            if ({rdata.code, rdata.seq} == {code_q, seq_q}) begin
              if (rdata.status.rcv == 2'd0) ns.age = 2'd0;
              if (rdata.status.rcv < 2'd2) ns.rcv = rdata.status.rcv + 2'd1;
              we      = 1'b1;
              waddr   = rd_q[IdxW-1:0];
              wdata   = rdata;
              wdata.status = ns;
              ev_end  = 1'b1;
              emit    = 1'b1;
              okind_d = KIND_FOUND;
              oent_d  = rdata;
              orep_d  = ns.server && (ns.rcv > 2'd1) && ns.payload;
            end
          end
          CMD_RELEASE: begin
            if (rdata.status.server && rdata.status.before_login) begin
              ns.before_login = 1'b0;
              we      = 1'b1;
              waddr   = rd_q[IdxW-1:0];
              wdata.status = ns;
              emit    = 1'b1;
              okind_d = KIND_PROCESS;
              oent_d  = rdata;
              olast_d = 1'b0;
            end
          end
          default: begin
            oent_d  = rdata;
            olast_d = 1'b0;
            if (!copy_q && !rdata.status.before_login) begin
              ns.age = age_n;
              if (age_n <= 2'd1) begin
                keep = 1'b1;
              end else if (rdata.status.rcv != 2'd0) begin
                keep = 1'b0;
              end else if (rdata.status.server) begin
                keep = 1'b1;
              end else if (rdata.status.retries <= 3'd1) begin
                ns.retries = 3'd0;
                emit       = 1'b1;
                if (rdata.status.important) begin
                  okind_d = KIND_LOST_IMP;
                  olast_d = 1'b1;
                  copy_d  = 1'b1;
                end else begin
                  okind_d = KIND_LOST;
                  keep    = 1'b0;
                end
              end else begin
                ns.retries = rdata.status.retries - 3'd1;
                emit       = 1'b1;
                okind_d    = KIND_RESEND;
              end
            end
            if (keep) begin
              we           = 1'b1;
              wdata.status = ns;
              wr_d         = wr_q + 1'b1;
            end
          end
        endcase
      end
      DP_FIN: begin
        unique case (cmd_q)
          CMD_RECEIVE: begin
            emit    = 1'b1;
            okind_d = KIND_NOT_FOUND;
          end
          CMD_SCAN: begin
            count_d = wr_q;
            emit    = !copy_q;
          end
          CMD_CLEAR: begin
            count_d = '0;
            emit    = 1'b1;
          end
          default: emit = 1'b1;
        endcase
      end
      default: ;
    endcase

    if (emit) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  assign stat_o.in_cmd   = cmd_e'(cmd_i);
  assign stat_o.rd_done  = rd_q >= count_q;
  assign stat_o.can_emit = can_emit;
  assign stat_o.ev_end   = ev_end;

  assign out_valid_o         = ovalid_q;
  assign kind_o              = okind_q;
  assign entry_code_o        = oent_q.code;
  assign entry_seq_o         = oent_q.seq;
  assign entry_room_op_o     = oent_q.room_op;
  assign entry_room_number_o = oent_q.room_number;
  assign entry_is_server_o   = oent_q.status.server;
  assign repeat_reply_o      = orep_q;
  assign last_o              = olast_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond table depth");
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("compaction write index ahead of read index");
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DP_ADD && count_q < DepthC) |=> count_q == $past(count_q) + 1'b1)
    else $error("add did not grow the table");
`endif

endmodule

FILE: sv/pending_transaction_retry_table.sv
// Top level of the pending transaction retry table: APB register file,
// controller and datapath. Depends on ptrt_pkg, ptrt_ctrl, ptrt_dp.
//
// Usage: an input transaction (cmd and message fields) is taken when
// in_valid_i is high and in_stall_o low. Each transaction yields one or more
// result transactions on the output channel, the final one with last_o set.
// Receive, scan and release walk the table in order, with one RAM read and
// then one evaluate and write back per entry visited, and a closing step
// unless a receive finds its entry.
// Scan compacts the table as it goes, so removals keep entry order.
// One transaction is worked at a time; in_stall_o is high until the walk is
// finished and the last result has been loaded into the output register.
// A stalled output holds its transaction and the walk pauses until it is taken.
// Reset empties the table (entry count zero), sets retry_budget to 3 and
// room_message_code to 0; entry contents need no clearing.
// Registers: retry_budget at 0x0, room_message_code at 0x4.
`timescale 1ns / 1ps
module pending_transaction_retry_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] msg_code_i,
  input  logic [15:0] msg_seq_i,
  input  logic        important_i,
  input  logic        logged_in_i,
  input  logic        has_payload_i,
  input  logic [7:0]  room_op_i,
  input  logic [31:0] room_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [15:0] entry_code_o,
  output logic [15:0] entry_seq_o,
  output logic [7:0]  entry_room_op_o,
  output logic [31:0] entry_room_number_o,
  output logic        entry_is_server_o,
  output logic        repeat_reply_o,
  output logic        last_o
);
  import ptrt_pkg::*;

  logic [2:0]  retry_q;
  logic [15:0] room_code_q;
  logic        wr_en;
  dp_stat_t    stat;
  dp_op_e      op;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q     <= RETRY_RESET;
      room_code_q <= '0;
    end else if (wr_en) begin
      if (paddr == ADDR_RETRY_BUDGET) retry_q <= pwdata[2:0];
      if (paddr == ADDR_ROOM_CODE) room_code_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_RETRY_BUDGET) prdata = {29'd0, retry_q};
    else if (paddr == ADDR_ROOM_CODE) prdata = {16'd0, room_code_q};
  end

  ptrt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .op_o      (op)
  );

  ptrt_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .stat_o             (stat),
    .retry_budget_i     (retry_q),
    .room_code_i        (room_code_q),
    .cmd_i              (cmd_i),
    .msg_code_i         (msg_code_i),
    .msg_seq_i          (msg_seq_i),
    .important_i        (important_i),
    .logged_in_i        (logged_in_i),
    .has_payload_i      (has_payload_i),
    .room_op_i          (room_op_i),
    .room_number_i      (room_number_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .entry_code_o       (entry_code_o),
    .entry_seq_o        (entry_seq_o),
    .entry_room_op_o    (entry_room_op_o),
    .entry_room_number_o(entry_room_number_o),
    .entry_is_server_o  (entry_is_server_o),
    .repeat_reply_o     (repeat_reply_o),
    .last_o             (last_o)
  );

endmodule

FILE: tb/pending_transaction_retry_table_tb.sv
// Self-checking testbench for pending_transaction_retry_table: queue-fed driver,
// clocked monitor and a behavioural table predictor. Depends on ptrt_pkg and the RTL.
`timescale 1ns / 1ps
module pending_transaction_retry_table_tb;
  import ptrt_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] code;
    logic [15:0] seq;
    logic        imp;
    logic        login;
    logic        pay;
    logic [7:0]  rop;
    logic [31:0] rnum;
  } msg_t;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] code;
    logic [15:0] seq;
    logic [7:0]  rop;
    logic [31:0] rnum;
    logic        srv;
    logic        rep;
    logic        last;
  } outcome_t;

  typedef struct {
    logic [15:0] code;
    logic [15:0] seq;
    logic [7:0]  rop;
    logic [31:0] rnum;
    logic        srv;
    logic        pay;
    logic        imp;
    logic        pre_login;
    logic [2:0]  retries;
    logic [1:0]  rcv;
    logic [1:0]  age;
  } slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] cmd_i = '0;
  logic [15:0] msg_code_i = '0, msg_seq_i = '0;
  logic important_i = 1'b0, logged_in_i = 1'b0, has_payload_i = 1'b0;
  logic [7:0] room_op_i = '0;
  logic [31:0] room_number_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] kind_o;
  logic [15:0] entry_code_o, entry_seq_o;
  logic [7:0] entry_room_op_o;
  logic [31:0] entry_room_number_o;
  logic entry_is_server_o, repeat_reply_o, last_o;

  pending_transaction_retry_table u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  msg_t       pending_q[$];
  outcome_t   expected_q[$];
  logic [31:0] key_pool[$];
  slot_t      table_m[16];
  int         n_slots = 0;
  logic [2:0] budget_m = RETRY_RESET;
  logic [15:0] room_code_m = '0;
  int         send_idle = 0, recv_idle = 0;
  int         errors = 0;
  msg_t       cur;

  function automatic void push_result(logic [3:0] k, logic [15:0] c, logic [15:0] s,
                                      logic [7:0] ro, logic [31:0] rn, logic sv,
                                      logic rp);
    outcome_t o;
    o.kind = k; o.code = c; o.seq = s; o.rop = ro; o.rnum = rn;
    o.srv = sv; o.rep = rp; o.last = 1'b0;
    expected_q.push_back(o);
  endfunction

  function automatic void push_slot(logic [3:0] k, int i);
    push_result(k, table_m[i].code, table_m[i].seq, table_m[i].rop, table_m[i].rnum,
                table_m[i].srv, 1'b0);
  endfunction

  function automatic void drop_slot(int i);
    for (int j = i; j + 1 < n_slots; j++) table_m[j] = table_m[j + 1];
    n_slots--;
  endfunction

  function automatic void predict_table(msg_t m);
    slot_t e;
    int i;
    bit stopped;
    i = 0;
    stopped = 0;
    case (m.cmd)
      CMD_ADD_CLIENT, CMD_ADD_SERVER, CMD_ADD_ROOM: begin
        e = '{default: '0};
        e.code = m.code; e.seq = m.seq; e.pay = m.pay;
        if (m.cmd == CMD_ADD_CLIENT) begin
          e.imp = m.imp; e.retries = budget_m;
        end else if (m.cmd == CMD_ADD_SERVER) begin
          e.srv = 1'b1; e.pre_login = !m.login; e.rcv = 2'd1;
        end else begin
          e.code = room_code_m; e.rop = m.rop; e.rnum = m.rnum; e.retries = budget_m;
        end
        push_result(n_slots >= 16 ? KIND_FULL : KIND_ADDED, e.code, e.seq, e.rop,
                    e.rnum, e.srv, 1'b0);
        if (n_slots < 16) begin
          table_m[n_slots] = e;
          n_slots++;
        end
      end
      CMD_RECEIVE: begin
        while (i < n_slots && !(table_m[i].code == m.code && table_m[i].seq == m.seq)) i++;
        if (i < n_slots) begin
          if (table_m[i].rcv == 0) table_m[i].age = 0;
          if (table_m[i].rcv < 2) table_m[i].rcv++;
          push_result(KIND_FOUND, table_m[i].code, table_m[i].seq, table_m[i].rop,
                      table_m[i].rnum, table_m[i].srv,
                      table_m[i].srv && table_m[i].rcv > 1 && table_m[i].pay);
        end else begin
          push_result(KIND_NOT_FOUND, '0, '0, '0, '0, 1'b0, 1'b0);
        end
      end
      CMD_SCAN: begin
        while (i < n_slots && !stopped) begin
          if (table_m[i].pre_login) begin
            i++;
          end else begin
            if (table_m[i].age < 2) table_m[i].age++;
            if (table_m[i].age <= 1 || (table_m[i].srv && table_m[i].rcv == 0)) begin
              i++;
            end else if (table_m[i].rcv > 0) begin
              drop_slot(i);
            end else if (table_m[i].retries <= 1) begin
              table_m[i].retries = 0;
              if (table_m[i].imp) begin
                push_slot(KIND_LOST_IMP, i);
                stopped = 1;
              end else begin
                push_slot(KIND_LOST, i);
                drop_slot(i);
              end
            end else begin
              table_m[i].retries--;
              push_slot(KIND_RESEND, i);
              i++;
            end
          end
        end
        if (!stopped) push_result(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b0);
      end
      CMD_RELEASE: begin
        for (i = 0; i < n_slots; i++)
          if (table_m[i].srv && table_m[i].pre_login) begin
            table_m[i].pre_login = 1'b0;
            push_slot(KIND_PROCESS, i);
          end
        push_result(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b0);
      end
      default: begin
        if (m.cmd == CMD_CLEAR) n_slots = 0;
        push_result(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b0);
      end
    endcase
    expected_q[$].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_table(cur);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= cur.cmd; msg_code_i <= cur.code; msg_seq_i <= cur.seq;
          important_i <= cur.imp; logged_in_i <= cur.login; has_payload_i <= cur.pay;
          room_op_i <= cur.rop; room_number_i <= cur.rnum;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d", $time, kind_o);
      end else begin
        x = expected_q.pop_front();
        if (kind_o !== x.kind || entry_code_o !== x.code || entry_seq_o !== x.seq ||
            entry_room_op_o !== x.rop || entry_room_number_o !== x.rnum ||
            entry_is_server_o !== x.srv || repeat_reply_o !== x.rep || last_o !== x.last) begin
          errors++;
          $display("%0t: mismatch exp k%0d %h %h %h %h s%b r%b l%b got k%0d %h %h %h %h s%b r%b l%b",
                   $time, x.kind, x.code, x.seq, x.rop, x.rnum, x.srv, x.rep, x.last,
                   kind_o, entry_code_o, entry_seq_o, entry_room_op_o, entry_room_number_o,
                   entry_is_server_o, repeat_reply_o, last_o);
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_RETRY_BUDGET) budget_m = d[2:0];
    else room_code_m = d[15:0];
  endtask

  task automatic queue_msg(logic [2:0] c, logic [15:0] code, logic [15:0] seq,
                           logic imp, logic login, logic pay, logic [7:0] rop,
                           logic [31:0] rnum);
    msg_t m;
    m = '{c, code, seq, imp, login, pay, rop, rnum};
    pending_q.push_back(m);
    if (c == CMD_ADD_CLIENT || c == CMD_ADD_SERVER) key_pool.push_back({code, seq});
    if (c == CMD_ADD_ROOM) key_pool.push_back({room_code_m, seq});
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    int w;
    logic [15:0] c, s, rc;
    logic [31:0] k;
    logic        b0, b1, b2;
    logic [7:0]  ro;
    logic [31:0] rn;
    for (int t = 0; t < n; t++) begin
      w = $urandom_range(99);
      b0 = 1'($urandom); b1 = 1'($urandom); b2 = 1'($urandom);
      ro = 8'($urandom); rn = $urandom; rc = 16'($urandom);
      if (w < 10) begin
        c = 16'($urandom); s = 16'($urandom);
      end else begin
        c = 16'($urandom_range(3)); s = 16'($urandom_range(7));
      end
      if (w < 25) queue_msg(CMD_ADD_CLIENT, c, s, b0, b1, b2, ro, rn);
      else if (w < 38) queue_msg(CMD_ADD_SERVER, c, s, b0, b1, b2, ro, rn);
      else if (w < 47) queue_msg(CMD_ADD_ROOM, rc, s, b0, b1, b2, ro, rn);
      else if (w < 73) begin
        if (key_pool.size() > 0 && $urandom_range(99) < 80)
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
          k = {c, s};
        queue_msg(CMD_RECEIVE, k[31:16], k[15:0], b0, b1, b2, ro, rn);
      end
      else if (w < 90) queue_msg(CMD_SCAN, c, s, b0, b1, b2, ro, rn);
      else if (w < 95) queue_msg(CMD_RELEASE, c, s, b0, b1, b2, ro, rn);
      else if (w < 97) queue_msg(CMD_CLEAR, c, s, b0, b1, b2, ro, rn);
      else queue_msg(CMD_NONE, c, s, b0, b1, b2, ro, rn);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 15; recv_idle = 87;
    reg_write(ADDR_RETRY_BUDGET, 32'd2);
    reg_write(ADDR_ROOM_CODE, 32'h1234);
    // directed
    queue_msg(CMD_ADD_CLIENT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_ADD_CLIENT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFFFFFF);
    queue_msg(CMD_ADD_SERVER, 16'h00AA, 16'h0001, 1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFFFFFF);
    queue_msg(CMD_ADD_SERVER, 16'h00BB, 16'h0002, 1'b0, 1'b0, 1'b1, 8'h00, 32'h0);
    queue_msg(CMD_ADD_ROOM, 16'hFFFF, 16'h0003, 1'b1, 1'b0, 1'b0, 8'hFF, 32'hFFFFFFFF);
    queue_msg(CMD_ADD_ROOM, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 8'h5A, 32'hA5A5A5A5);
    queue_msg(CMD_RECEIVE, 16'h00AA, 16'h0001, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_RECEIVE, 16'h00AA, 16'h0001, 1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFFFFFF);
    queue_msg(CMD_RECEIVE, 16'h1234, 16'h0003, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_RECEIVE, 16'hFFFF, 16'hFFFE, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_RELEASE, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFFFFFF);
    queue_msg(CMD_CLEAR, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    queue_msg(CMD_SCAN, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0);
    drain();
    reg_write(ADDR_RETRY_BUDGET, 32'd1);
    reg_write(ADDR_ROOM_CODE, 32'hFFFF);
    queue_random(130);
    drain();
    send_idle = 87; recv_idle = 15;
    reg_write(ADDR_RETRY_BUDGET, 32'd7);
    reg_write(ADDR_ROOM_CODE, 32'h0);
    queue_random(130);
    drain();
    send_idle = 0; recv_idle = 0;
    reg_write(ADDR_RETRY_BUDGET, 32'd0);
    reg_write(ADDR_ROOM_CODE, $urandom);
    queue_random(120);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ptrt_pkg.sv
sv/ptrt_ram.sv
sv/ptrt_ctrl.sv
sv/ptrt_dp.sv
sv/pending_transaction_retry_table.sv
tb/pending_transaction_retry_table_tb.sv
